// File: hw/rtl/countdown_seven_segment_scanner_defines.svh
// Assertion macros used by the checker of the scanner.
`ifndef COUNTDOWN_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define COUNTDOWN_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define CDSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdss checker: assertion failed");

// Check the consequent starting in the cycle after the antecedent.
`define CDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdss checker: assertion failed");

`endif

// File: hw/rtl/cdss_pkg.sv
// Types, command codes, constants and segment decode of the countdown scanner.
`default_nettype none

package cdss_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int SCAN_WIDTH  = $clog2(DIGIT_COUNT);
    localparam int MS_WIDTH    = 17;
    localparam int SECS_WIDTH  = 8;
    localparam int PAIR_WIDTH  = 7;
    localparam int SEG_WIDTH   = 7;

    // floor(ms / 1000) == (ms * RECIP) >> RECIP_SHIFT for every 17-bit ms
    localparam int RECIP_SHIFT = 27;
    localparam int PROD_WIDTH  = MS_WIDTH + 18;
    localparam logic [PROD_WIDTH-1:0] RECIP = PROD_WIDTH'(134218);

    // floor(s / 10) == (s * TENS_RECIP) >> TENS_SHIFT for s up to 99
    localparam int TENS_SHIFT = 10;
    localparam int TENS_PROD_WIDTH = 2 * PAIR_WIDTH;
    localparam logic [TENS_PROD_WIDTH-1:0] TENS_RECIP = TENS_PROD_WIDTH'(103);

    localparam logic [PAIR_WIDTH-1:0] MAX_SECONDS = PAIR_WIDTH'(99);

    typedef logic [3:0]            digit_t;
    typedef logic [2:0]            mode_t;
    typedef logic [SECS_WIDTH-1:0] secs_t;
    typedef logic [SEG_WIDTH-1:0]  seg_t;

    localparam digit_t DIGIT_ZERO  = 4'd0;
    localparam digit_t DIGIT_NINE  = 4'd9;
    localparam digit_t DIGIT_EIGHT = 4'd8;
    localparam digit_t DIGIT_TEN   = 4'd10;

    localparam mode_t MODE_SCAN   = 3'd0;
    localparam mode_t MODE_SECOND = 3'd1;
    localparam mode_t MODE_LOAD1  = 3'd2;
    localparam mode_t MODE_LOAD2  = 3'd3;
    localparam mode_t MODE_MANUAL = 3'd4;
    localparam mode_t MODE_ERROR  = 3'd5;

    typedef struct packed {
        mode_t  mode;
        secs_t  secs;
        digit_t shown_digit;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

    // Active-low segments a..g in bits 0..6; blank above nine.
    function automatic seg_t segments_for(input digit_t v);
        seg_t s;
        case (v)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h10;
            default: s = 7'h7F;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cdss_cmd_if.sv
// Command channel: valid/ready handshake with the command payload.
`default_nettype none

interface cdss_cmd_if;
    logic                                valid;
    logic                                ready;
    cdss_pkg::mode_t                     mode;
    logic [cdss_pkg::MS_WIDTH-1:0]       time_ms;
    cdss_pkg::digit_t                    shown_digit;

    modport source (output valid, output mode, output time_ms, output shown_digit,
                    input ready);
    modport sink   (input valid, input mode, input time_ms, input shown_digit,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cdss_disp_if.sv
// Display channel: valid/ready handshake with segments and digit enables.
`default_nettype none

interface cdss_disp_if;
    logic                                valid;
    logic                                ready;
    cdss_pkg::seg_t                      segments;
    logic [cdss_pkg::DIGIT_COUNT-1:0]    digit_enables;

    modport source (output valid, output segments, output digit_enables, input ready);
    modport sink   (input valid, input segments, input digit_enables, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/countdown_seven_segment_scanner.sv
// Top level of the four-digit multiplexed countdown display driver.
//
// Every command beat produces exactly one display beat: the active-low segment
// pattern and one-cold digit enable of the scanned digit after the command is
// applied. A new command can be taken every cycle while the display side takes
// results. After the command is taken, it passes through the input register,
// where a reciprocal multiply turns milliseconds into seconds, and then the
// digit stage, which updates the digit store and the scan position and
// registers the decoded result. The input side keeps accepting while a result
// waits on the display side, until both registers are full.
`default_nettype none

module countdown_seven_segment_scanner (
    input  wire logic      clk,
    input  wire logic      rst_n,
    cdss_cmd_if.sink       cmd,
    cdss_disp_if.source    disp
);

    cdss_pkg::cmd_beat_t   beat;
    logic                  take;

    cdss_cmd_stage u_cmd_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .beat  (beat),
        .take  (take)
    );

    cdss_digit_stage u_digit_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .take  (take),
        .disp  (disp)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cdss_cmd_stage.sv
// Input register: accept a command beat and convert milliseconds to seconds.
`default_nettype none

module cdss_cmd_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cdss_cmd_if.sink               cmd,
    output cdss_pkg::cmd_beat_t    beat,
    input  wire logic              take
);

    logic                                 valid_reg;
    logic                                 valid_next;
    cdss_pkg::cmd_t                       cmd_reg;
    logic [cdss_pkg::PROD_WIDTH-1:0]      prod;
    cdss_pkg::secs_t                      secs;

    assign cmd.ready = !valid_reg || take;

    assign prod = cdss_pkg::PROD_WIDTH'(cmd.time_ms) * cdss_pkg::RECIP;
    assign secs = prod[cdss_pkg::RECIP_SHIFT +: cdss_pkg::SECS_WIDTH];

    assign valid_next = cmd.ready ? cmd.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.mode        <= cmd.mode;
            cmd_reg.secs        <= secs;
            cmd_reg.shown_digit <= cmd.shown_digit;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.cmd   = cmd_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cdss_digit_stage.sv
// Digit store, scan position, command decode and the display result register.
`default_nettype none

module cdss_digit_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cdss_pkg::cmd_beat_t beat,
    output logic                   take,
    cdss_disp_if.source            disp
);

    cdss_pkg::digit_t                       digits_reg  [cdss_pkg::DIGIT_COUNT];
    cdss_pkg::digit_t                       digits_next [cdss_pkg::DIGIT_COUNT];
    logic [cdss_pkg::SCAN_WIDTH-1:0]        scan_reg;
    logic [cdss_pkg::SCAN_WIDTH-1:0]        scan_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    cdss_pkg::seg_t                         seg_reg;
    cdss_pkg::seg_t                         seg_next;
    logic [cdss_pkg::DIGIT_COUNT-1:0]       en_reg;
    logic [cdss_pkg::DIGIT_COUNT-1:0]       en_next;
    logic                                   fire;
    logic [cdss_pkg::PAIR_WIDTH-1:0]        sat;
    logic [cdss_pkg::TENS_PROD_WIDTH-1:0]   tens_prod;
    cdss_pkg::digit_t                       load_tens;
    cdss_pkg::digit_t                       load_ones;
    logic [7:0]                             pair1_down;
    logic [7:0]                             pair2_down;

    function automatic logic [7:0] count_down(input cdss_pkg::digit_t tens,
                                              input cdss_pkg::digit_t ones);
        cdss_pkg::digit_t t;
        cdss_pkg::digit_t o;
        t = tens;
        o = ones;
        if (ones != cdss_pkg::DIGIT_ZERO)
        begin
            o = ones - 4'd1;
        end
        else if (tens != cdss_pkg::DIGIT_ZERO)
        begin
            o = cdss_pkg::DIGIT_NINE;
            t = tens - 4'd1;
        end
        return {t, o};
    endfunction

    assign take = !out_valid_reg || disp.ready;
    assign fire = beat.valid && take;

    // saturate, then split into tens and ones
    assign sat = (beat.cmd.secs > cdss_pkg::SECS_WIDTH'(cdss_pkg::MAX_SECONDS))
               ? cdss_pkg::MAX_SECONDS
               : beat.cmd.secs[cdss_pkg::PAIR_WIDTH-1:0];
    assign tens_prod = cdss_pkg::TENS_PROD_WIDTH'(sat) * cdss_pkg::TENS_RECIP;
    assign load_tens = tens_prod[cdss_pkg::TENS_SHIFT +: 4];
    assign load_ones = 4'(sat - cdss_pkg::PAIR_WIDTH'(load_tens)
                                * cdss_pkg::PAIR_WIDTH'(cdss_pkg::DIGIT_TEN));

    assign pair1_down = count_down(digits_reg[0], digits_reg[1]);
    assign pair2_down = count_down(digits_reg[2], digits_reg[3]);

    always_comb
    begin
        digits_next = digits_reg;
        scan_next   = scan_reg;
        if (fire)
        begin
            case (beat.cmd.mode)
                cdss_pkg::MODE_SCAN:
                begin
                    scan_next = scan_reg + 1'b1;
                end
                cdss_pkg::MODE_SECOND:
                begin
                    digits_next[0] = pair1_down[7:4];
                    digits_next[1] = pair1_down[3:0];
                    digits_next[2] = pair2_down[7:4];
                    digits_next[3] = pair2_down[3:0];
                end
                cdss_pkg::MODE_LOAD1:
                begin
                    digits_next[0] = load_tens;
                    digits_next[1] = load_ones;
                end
                cdss_pkg::MODE_LOAD2:
                begin
                    digits_next[2] = load_tens;
                    digits_next[3] = load_ones;
                end
                cdss_pkg::MODE_MANUAL:
                begin
                    digits_next[0] = cdss_pkg::DIGIT_ZERO;
                    digits_next[1] = beat.cmd.shown_digit;
                    digits_next[2] = load_tens;
                    digits_next[3] = load_ones;
                end
                cdss_pkg::MODE_ERROR:
                begin
                    for (int i = 0; i < cdss_pkg::DIGIT_COUNT; i++)
                    begin
                        digits_next[i] = cdss_pkg::DIGIT_EIGHT;
                    end
                end
                default:
                begin
                    scan_next = scan_reg;
                end
            endcase
        end
    end

    assign seg_next       = cdss_pkg::segments_for(digits_next[scan_next]);
    assign en_next        = ~(cdss_pkg::DIGIT_COUNT'(1) << scan_next);
    assign out_valid_next = take ? beat.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cdss_pkg::DIGIT_COUNT; i++)
            begin
                digits_reg[i] <= cdss_pkg::DIGIT_ZERO;
            end
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            digits_reg    <= digits_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            seg_reg <= seg_next;
            en_reg  <= en_next;
        end
    end

    assign disp.valid         = out_valid_reg;
    assign disp.segments      = seg_reg;
    assign disp.digit_enables = en_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cdss_checker.sv
// Port-level checker for the countdown scanner and its bind to the top level.
`default_nettype none
`include "countdown_seven_segment_scanner_defines.svh"

module cdss_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             cmd_valid,
    input wire logic                             cmd_ready,
    input wire logic                             disp_valid,
    input wire logic                             disp_ready,
    input wire logic [cdss_pkg::DIGIT_COUNT-1:0] digit_enables
);

    `CDSS_ASSERT_NEXT(a_disp_hold, clk, rst_n, disp_valid && !disp_ready, disp_valid)
    `CDSS_ASSERT_SAME(a_enable_cold, clk, rst_n, disp_valid, $onehot(~digit_enables))
    `CDSS_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !disp_valid, cmd_ready)
    `CDSS_ASSERT_NEXT(a_result_follows, clk, rst_n, cmd_valid && cmd_ready, ##1 disp_valid)

endmodule

bind countdown_seven_segment_scanner cdss_checker u_cdss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .disp_valid    (disp.valid),
    .disp_ready    (disp.ready),
    .digit_enables (disp.digit_enables)
);

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the countdown seven-segment scanner.
`timescale 1ns / 100ps

module tb;

    import cdss_pkg::*;

    localparam mode_t MODE_SPARE_A = 3'd6;
    localparam mode_t MODE_SPARE_B = 3'd7;

    localparam int MS_PER_SECOND  = 1000;
    localparam int RANDOM_ITEMS   = 450;
    localparam int PACE_BLOCK     = 50;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 6;

    typedef struct packed {
        seg_t                   segments;
        logic [DIGIT_COUNT-1:0] digit_enables;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cdss_cmd_if  cmd_bus ();
    cdss_disp_if disp_bus ();

    countdown_seven_segment_scanner u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .disp  (disp_bus)
    );

    digit_t                digit_model [DIGIT_COUNT];
    logic [SCAN_WIDTH-1:0] scan_pos = '0;
    frame_t                expected_frames [$];

    bit cmd_pace_on  = 1'b0;
    bit disp_pace_on = 1'b0;

    int fail_count     = 0;
    int cmds_sent      = 0;
    int second_ticks   = 0;
    int load_cmds      = 0;
    int frames_checked = 0;
    int idle_cycles    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic load_pair(input int base, input logic [MS_WIDTH-1:0] ms);
        int secs;
        secs = ms / MS_PER_SECOND;
        if (secs > MAX_SECONDS)
            secs = MAX_SECONDS;
        digit_model[base]     = digit_t'(secs / 10);
        digit_model[base + 1] = digit_t'(secs % 10);
    endtask

    task automatic count_down_pair(input int base);
        digit_t tens;
        digit_t ones;
        tens = digit_model[base];
        ones = digit_model[base + 1];
        if (ones != DIGIT_ZERO)
            ones = ones - 1'b1;
        else if (tens != DIGIT_ZERO)
        begin
            ones = DIGIT_NINE;
            tens = tens - 1'b1;
        end
        digit_model[base]     = tens;
        digit_model[base + 1] = ones;
    endtask

    task automatic apply_display_cmd(input mode_t op, input logic [MS_WIDTH-1:0] ms,
                                     input digit_t shown);
        frame_t frame;
        seg_t   lit;
        case (op)
            MODE_SCAN:   scan_pos = scan_pos + 1'b1;
            MODE_SECOND:
            begin
                count_down_pair(0);
                count_down_pair(2);
                second_ticks++;
            end
            MODE_LOAD1:
            begin
                load_pair(0, ms);
                load_cmds++;
            end
            MODE_LOAD2:
            begin
                load_pair(2, ms);
                load_cmds++;
            end
            MODE_MANUAL:
            begin
                digit_model[0] = DIGIT_ZERO;
                digit_model[1] = shown;
                load_pair(2, ms);
                load_cmds++;
            end
            MODE_ERROR:
            begin
                foreach (digit_model[i])
                    digit_model[i] = DIGIT_EIGHT;
            end
            default: ;
        endcase
        case (digit_model[scan_pos])
            4'd0:    lit = 7'h3F;
            4'd1:    lit = 7'h06;
            4'd2:    lit = 7'h5B;
            4'd3:    lit = 7'h4F;
            4'd4:    lit = 7'h66;
            4'd5:    lit = 7'h6D;
            4'd6:    lit = 7'h7D;
            4'd7:    lit = 7'h07;
            4'd8:    lit = 7'h7F;
            4'd9:    lit = 7'h6F;
            default: lit = 7'h00;
        endcase
        frame.segments      = ~lit;
        frame.digit_enables = ~(4'b0001 << scan_pos);
        expected_frames.push_back(frame);
        cmds_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
            apply_display_cmd(cmd_bus.mode, cmd_bus.time_ms, cmd_bus.shown_digit);
    end

    always @(posedge clk)
    begin : check_display
        frame_t want;
        if (rst_n && disp_bus.valid && disp_bus.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("display beat with no command pending: segments %h, enables %b",
                       disp_bus.segments, disp_bus.digit_enables);
                fail_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (disp_bus.segments !== want.segments)
                begin
                    $error("segments: expected %h, got %h", want.segments,
                           disp_bus.segments);
                    fail_count++;
                end
                if (disp_bus.digit_enables !== want.digit_enables)
                begin
                    $error("digit_enables: expected %b, got %b", want.digit_enables,
                           disp_bus.digit_enables);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (disp_bus.valid && disp_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : display_sink
        int stall;
        disp_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = disp_pace_on ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                disp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            disp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!disp_bus.valid);
        end
    end

    task automatic issue_command(input mode_t op, input logic [MS_WIDTH-1:0] ms,
                                 input digit_t shown);
        int gap;
        gap = cmd_pace_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.mode        <= op;
        cmd_bus.time_ms     <= ms;
        cmd_bus.shown_digit <= shown;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    function automatic logic [MS_WIDTH-1:0] random_time_ms();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return MS_WIDTH'($urandom_range(0, 999));
            6:       return MS_WIDTH'($urandom_range(98000, 100999));
            7:       return MS_WIDTH'($urandom_range(100000, 131071));
            8:       return MS_WIDTH'($urandom_range(0, 131071));
            9:       return MS_WIDTH'($urandom_range(0, 99) * MS_PER_SECOND
                                      + ($urandom_range(0, 1) ? 999 : 0));
            default: return MS_WIDTH'($urandom_range(0, 99999));
        endcase
    endfunction

    function automatic mode_t random_mode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return MODE_SCAN;
        else if (roll < 65)
            return MODE_SECOND;
        else if (roll < 75)
            return MODE_LOAD1;
        else if (roll < 85)
            return MODE_LOAD2;
        else if (roll < 93)
            return MODE_MANUAL;
        else if (roll < 96)
            return MODE_ERROR;
        else if (roll < 98)
            return MODE_SPARE_A;
        return MODE_SPARE_B;
    endfunction

    task automatic test_unused_codes();
        issue_command(MODE_SPARE_B, 17'h1FFFF, 4'hF);
        issue_command(MODE_SPARE_A, 17'h00000, 4'h0);
    endtask

    task automatic test_load_saturation();
        issue_command(MODE_LOAD1, 17'd131071, DIGIT_ZERO);
        issue_command(MODE_LOAD2, 17'd100000, DIGIT_ZERO);
        issue_command(MODE_SCAN, 17'd0, DIGIT_ZERO);
        issue_command(MODE_LOAD1, 17'd99999, DIGIT_ZERO);
        issue_command(MODE_LOAD2, 17'd999, DIGIT_ZERO);
        issue_command(MODE_SCAN, 17'd0, DIGIT_ZERO);
        issue_command(MODE_LOAD2, 17'd45678, DIGIT_ZERO);
        issue_command(MODE_SCAN, 17'd0, DIGIT_ZERO);
    endtask

    task automatic test_countdown_borrow();
        issue_command(MODE_LOAD1, 17'd10000, DIGIT_ZERO);
        issue_command(MODE_LOAD2, 17'd1000, DIGIT_ZERO);
        issue_command(MODE_SECOND, 17'd0, DIGIT_ZERO);
        issue_command(MODE_SECOND, 17'd0, DIGIT_ZERO);
        issue_command(MODE_LOAD1, 17'd0, DIGIT_ZERO);
        issue_command(MODE_SECOND, 17'd0, DIGIT_ZERO);
    endtask

    task automatic test_manual_view();
        issue_command(MODE_MANUAL, 17'd61999, 4'hF);
        issue_command(MODE_SECOND, 17'd0, DIGIT_ZERO);
        issue_command(MODE_MANUAL, 17'd0, DIGIT_NINE);
        issue_command(MODE_SCAN, 17'd0, DIGIT_ZERO);
    endtask

    task automatic test_error_fill();
        issue_command(MODE_ERROR, 17'd0, DIGIT_ZERO);
        repeat (3) issue_command(MODE_SCAN, 17'd0, DIGIT_ZERO);
    endtask

    task automatic test_random_commands();
        digit_t shown;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PACE_BLOCK == 0)
            begin
                cmd_pace_on  = (n != 0) && ($urandom_range(0, 3) != 0);
                disp_pace_on = (n != 0) && ($urandom_range(0, 3) != 0);
            end
            shown = ($urandom_range(0, 4) == 0) ? digit_t'($urandom_range(10, 15))
                                                : digit_t'($urandom_range(0, 9));
            issue_command(random_mode(), random_time_ms(), shown);
        end
    endtask

    initial
    begin
        foreach (digit_model[i])
            digit_model[i] = DIGIT_ZERO;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.mode        <= MODE_SCAN;
        cmd_bus.time_ms     <= '0;
        cmd_bus.shown_digit <= DIGIT_ZERO;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        cmd_pace_on  = 1'b1;
        disp_pace_on = 1'b1;
        test_unused_codes();
        test_load_saturation();
        cmd_pace_on  = 1'b0;
        disp_pace_on = 1'b1;
        test_countdown_borrow();
        cmd_pace_on  = 1'b1;
        disp_pace_on = 1'b0;
        test_manual_view();
        test_error_fill();
        test_random_commands();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);

        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands (%0d second ticks, %0d loads) with random pacing;",
                 cmds_sent, second_ticks, load_cmds);
        $display("checked %0d display beats against the digit store model.", frames_checked);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
